[src/bed_pkg.sv]
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types and constants for the backslash escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

    // Depth of the queue between the classifier and the emitter (power of two, >= 2)
    localparam int unsigned BED_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_final;
    } t_out_word;

    // One classified input byte: one or two result words
    typedef struct packed {
        logic      two;
        t_out_word w0;
        t_out_word w1;
    } t_entry;

    // Classifier to queue
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_enq;

    // Queue to emitter
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_deq;

endpackage

[src/bed_front.sv]
// ----------------------------------------------------------------------------
// bed_front
// Accepts raw bytes, tracks the escape state and classifies each byte into
// zero, one or two result words.
// ----------------------------------------------------------------------------
module bed_front
    import bed_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_word i_word,
    output t_enq     o_enq
);

    typedef enum logic [1:0] {
        M_TEXT = 2'd0,
        M_ESC  = 2'd1,
        M_HEX1 = 2'd2,
        M_HEX2 = 2'd3
    } t_mode;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;

    t_mode      r_mode, n_mode;
    logic [3:0] r_nib, n_nib;

    logic       d_ok;
    logic [3:0] d_val;
    logic       pre;
    logic [7:0] pre_byte;
    logic       one;
    logic [7:0] one_byte;
    logic       one_fin;
    logic       use_text;
    logic       text_emit;
    logic [7:0] b;
    logic       fin;
    t_entry     ent;
    logic       emit;

    assign b   = i_word.in_byte;
    assign fin = i_word.is_final;

    always_comb begin
        d_ok  = 1'b1;
        d_val = 4'h0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d_val = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            d_val = b[3:0] + 4'd9;
        end else begin
            d_ok = 1'b0;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_nib     = r_nib;
        pre       = 1'b0;
        pre_byte  = CH_X;
        one       = 1'b0;
        one_byte  = b;
        one_fin   = fin;
        use_text  = 1'b0;
        text_emit = 1'b0;
        unique case (r_mode)
            M_ESC: begin
                n_mode = M_TEXT;
                one    = 1'b1;
                unique case (b)
                    8'h6E:   one_byte = 8'h0A;
                    8'h72:   one_byte = 8'h0D;
                    8'h74:   one_byte = 8'h09;
                    8'h61:   one_byte = 8'h07;
                    8'h66:   one_byte = 8'h0C;
                    8'h65:   one_byte = 8'h1B;
                    CH_X: begin
                        // open a hex escape unless the string ends here
                        if (!fin) begin
                            one    = 1'b0;
                            n_mode = M_HEX1;
                        end
                    end
                    default: one_byte = b;
                endcase
            end
            M_HEX1: begin
                if (d_ok) begin
                    if (fin) begin
                        n_mode   = M_TEXT;
                        one      = 1'b1;
                        one_byte = {4'h0, d_val};
                    end else begin
                        n_nib  = d_val;
                        n_mode = M_HEX2;
                    end
                end else begin
                    pre      = 1'b1;
                    pre_byte = CH_X;
                    use_text = 1'b1;
                end
            end
            M_HEX2: begin
                if (d_ok) begin
                    n_mode   = M_TEXT;
                    one      = 1'b1;
                    one_byte = {r_nib, d_val};
                end else begin
                    pre      = 1'b1;
                    pre_byte = {4'h0, r_nib};
                    use_text = 1'b1;
                end
            end
            default: use_text = 1'b1;
        endcase

        // plain text: a backslash opens an escape unless it is the last byte
        if (use_text) begin
            if (b == BACKSLASH && !fin) begin
                n_mode = M_ESC;
            end else begin
                n_mode    = M_TEXT;
                text_emit = 1'b1;
            end
        end
    end

    always_comb begin
        ent  = '0;
        emit = 1'b1;
        if (pre) begin
            ent.w0.out_byte  = pre_byte;
            ent.w0.out_final = text_emit ? 1'b0 : fin;
            if (text_emit) begin
                ent.two          = 1'b1;
                ent.w1.out_byte  = b;
                ent.w1.out_final = fin;
            end
        end else if (text_emit) begin
            ent.w0.out_byte  = b;
            ent.w0.out_final = fin;
        end else if (one) begin
            ent.w0.out_byte  = one_byte;
            ent.w0.out_final = one_fin;
        end else begin
            emit = 1'b0;
        end
    end

    assign o_enq.valid = i_accept && emit;
    assign o_enq.entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_TEXT;
            r_nib  <= 4'h0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_nib  <= n_nib;
        end
    end

endmodule

[src/bed_fifo.sv]
// ----------------------------------------------------------------------------
// bed_fifo
// Short queue of classified entries between the classifier and the emitter.
// ----------------------------------------------------------------------------
module bed_fifo
    import bed_pkg::*;
#(
    parameter int unsigned Depth = BED_FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_enq                       i_enq,
    input  logic                       i_take,
    output t_deq                       o_deq,
    output logic                       o_full,
    output logic [$clog2(Depth+1)-1:0] o_count
);

    localparam int unsigned AW = $clog2(Depth);
    localparam int unsigned CW = $clog2(Depth + 1);

    t_entry          mem [Depth];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            do_wr, do_rd;

    assign do_wr = i_enq.valid && !o_full;
    assign do_rd = i_take && (r_count != '0);

    assign o_full      = (r_count == CW'(Depth));
    assign o_count     = r_count;
    assign o_deq.valid = (r_count != '0);
    assign o_deq.entry = mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            mem[r_wr] <= i_enq.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wr <= r_wr + AW'(1);
            end
            if (do_rd) begin
                r_rd <= r_rd + AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[src/bed_back.sv]
// ----------------------------------------------------------------------------
// bed_back
// Holds one classified entry and presents its words one per pop.
// ----------------------------------------------------------------------------
module bed_back
    import bed_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_deq      i_deq,
    output logic      o_take,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_word o_word
);

    logic   r_have;
    logic   r_idx;
    t_entry r_ent;
    logic   pop_ok;
    logic   last;

    assign pop_ok  = i_pop && r_have;
    assign last    = r_idx || !r_ent.two;
    // refill when idle or when the last word of the held entry leaves
    assign o_take  = i_deq.valid && (!r_have || (pop_ok && last));
    assign o_empty = !r_have;
    assign o_word  = r_idx ? r_ent.w1 : r_ent.w0;

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ent <= i_deq.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= 1'b0;
        end else if (o_take) begin
            r_have <= 1'b1;
            r_idx  <= 1'b0;
        end else if (pop_ok) begin
            if (last) begin
                r_have <= 1'b0;
                r_idx  <= 1'b0;
            end else begin
                r_idx <= 1'b1;
            end
        end
    end

endmodule

[src/backslash_escape_decoder.sv]
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Decodes C-style backslash escapes, one byte per cycle while full is low.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle while full is low and yields the decoded bytes
// through a queue-style result port. A byte gives zero, one or two result
// words; each word leaves in its own cycle, so results drain at one word per
// cycle while pop is high. A queue of FifoDepth entries between the
// classifier and the emitter absorbs the extra words and result-side stalls;
// input stalls only when that queue fills.
module backslash_escape_decoder
    import bed_pkg::*;
#(
    parameter int unsigned FifoDepth = BED_FIFO_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_data,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_data
);

    localparam int unsigned CW = $clog2(FifoDepth + 1);

    t_enq          w_enq;
    t_deq          w_deq;
    logic          w_take;
    logic          w_accept;
    logic [CW-1:0] w_count;

    assign w_accept = push && !full;

    bed_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_word   (i_data),
        .o_enq    (w_enq)
    );

    bed_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (w_enq),
        .i_take  (w_take),
        .o_deq   (w_deq),
        .o_full  (full),
        .o_count (w_count)
    );

    bed_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_deq   (w_deq),
        .o_take  (w_take),
        .i_pop   (pop),
        .o_empty (empty),
        .o_word  (o_data)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(FifoDepth))
        else $error("queue count exceeds depth");

    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && w_count != '0) |=> !empty)
        else $error("emitter idle while queue holds entries");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not empty after reset");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the backslash escape decoder.
// ----------------------------------------------------------------------------
// A queue of raw bytes feeds a clocked driver; a clocked monitor pops decoded
// words and compares them with the words that a local escape decoder predicts
// for every accepted byte. A short directed string set covers every escape and
// the hex corner cases, then random strings built from escape tokens run
// under random idling, a long result-side hold-off and a full sender pause.
// ----------------------------------------------------------------------------
module tb;
    import bed_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    // Escape characters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_X      = 8'h78;

    // Control codes the escapes stand for
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_ESC = 8'h1B;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_HEX1,
        MODE_HEX2
    } t_dec_mode;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_word  i_data  = '0;
    logic      full;
    logic      empty;
    t_out_word o_data;

    // Predicted decoder state
    t_dec_mode dec_mode = MODE_TEXT;
    logic [3:0] held_nib = 4'h0;

    t_in_word  pending_bytes[$];
    t_out_word decoded_words[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit rx_hold     = 1'b0;
    int tx_gap      = 0;
    int rx_gap      = 0;

    int n_bytes      = 0;
    int n_words      = 0;
    int n_strings    = 0;
    int n_pair_steps = 0;
    int n_in_stalls  = 0;
    int n_errors     = 0;
    int n_queued     = 0;
    int cycle_count  = 0;

    backslash_escape_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Escape decoder prediction
    // ------------------------------------------------------------------------
    // Bit 4 flags a hex digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b - 8'h30;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = b - 8'h57;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = b - 8'h37;
        end else begin
            return 5'h00;
        end
        return {1'b1, v[3:0]};
    endfunction

    task automatic queue_result(input logic [7:0] b, input logic fin);
        t_out_word w;
        w.out_byte  = b;
        w.out_final = fin;
        decoded_words.push_back(w);
    endtask

    task automatic plain_text(input logic [7:0] b, input logic fin);
        if (b == CH_BSLASH && !fin) begin
            dec_mode = MODE_ESC;
        end else begin
            dec_mode = MODE_TEXT;
            queue_result(b, fin);
        end
    endtask

    task automatic decode_byte(input t_in_word w);
        logic [4:0] h;
        int before_cnt;
        h = hex_nibble(w.in_byte);
        before_cnt = decoded_words.size();
        case (dec_mode)
            MODE_ESC: begin
                dec_mode = MODE_TEXT;
                case (w.in_byte)
                    CH_N: queue_result(CODE_LF, w.is_final);
                    CH_R: queue_result(CODE_CR, w.is_final);
                    CH_T: queue_result(CODE_TAB, w.is_final);
                    CH_A: queue_result(CODE_BEL, w.is_final);
                    CH_F: queue_result(CODE_FF, w.is_final);
                    CH_E: queue_result(CODE_ESC, w.is_final);
                    CH_X: begin
                        if (w.is_final) begin
                            queue_result(CH_X, 1'b1);
                        end else begin
                            dec_mode = MODE_HEX1;
                        end
                    end
                    default: queue_result(w.in_byte, w.is_final);
                endcase
            end
            MODE_HEX1: begin
                if (h[4]) begin
                    if (w.is_final) begin
                        dec_mode = MODE_TEXT;
                        queue_result({4'h0, h[3:0]}, 1'b1);
                    end else begin
                        held_nib = h[3:0];
                        dec_mode = MODE_HEX2;
                    end
                end else begin
                    // no digit: emit the x and take this byte as text
                    queue_result(CH_X, 1'b0);
                    plain_text(w.in_byte, w.is_final);
                end
            end
            MODE_HEX2: begin
                if (h[4]) begin
                    dec_mode = MODE_TEXT;
                    queue_result({held_nib, h[3:0]}, w.is_final);
                end else begin
                    queue_result({4'h0, held_nib}, 1'b0);
                    plain_text(w.in_byte, w.is_final);
                end
            end
            default: plain_text(w.in_byte, w.is_final);
        endcase
        if (decoded_words.size() - before_cnt == 2) begin
            n_pair_steps++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(40, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [7:0] esc_letter(input int idx);
        case (idx)
            0: return CH_N;
            1: return CH_R;
            2: return CH_T;
            3: return CH_A;
            4: return CH_F;
            5: return CH_E;
            default: return CH_BSLASH;
        endcase
    endfunction

    function automatic logic [7:0] rand_hex();
        case ($urandom_range(2))
            0: return 8'h30 + 8'($urandom_range(9));
            1: return 8'h61 + 8'($urandom_range(5));
            default: return 8'h41 + 8'($urandom_range(5));
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic fin);
        t_in_word w;
        w.in_byte  = b;
        w.is_final = fin;
        pending_bytes.push_back(w);
        n_queued++;
    endtask

    // Build one string from escape tokens; the last byte carries the final flag
    task automatic add_random_string();
        logic [7:0] s[$];
        int n_tok;
        n_tok = $urandom_range(6, 1);
        repeat (n_tok) begin
            case ($urandom_range(11))
                0, 1, 2: s.push_back(8'($urandom_range(255)));
                3, 4: begin
                    s.push_back(CH_BSLASH);
                    s.push_back(esc_letter($urandom_range(6)));
                end
                5: begin
                    s.push_back(CH_BSLASH);
                    s.push_back(8'($urandom_range(255)));
                end
                6, 7: begin
                    s.push_back(CH_BSLASH);
                    s.push_back(CH_X);
                    s.push_back(rand_hex());
                    s.push_back(rand_hex());
                end
                8: begin
                    s.push_back(CH_BSLASH);
                    s.push_back(CH_X);
                    s.push_back(rand_hex());
                end
                9: begin
                    s.push_back(CH_BSLASH);
                    s.push_back(CH_X);
                end
                default: s.push_back(CH_BSLASH);
            endcase
        end
        foreach (s[i]) begin
            add_byte(s[i], i == s.size() - 1);
        end
    endtask

    task automatic fill_random(input int count);
        int stop_at;
        stop_at = n_queued + count;
        while (n_queued < stop_at) begin
            if ($urandom_range(99) < 85) begin
                add_random_string();
            end else begin
                // noise: raw bytes with a stray final flag now and then
                repeat ($urandom_range(5, 1)) begin
                    add_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || push || decoded_words.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            dec_mode = MODE_TEXT;
            held_nib = 4'h0;
            tx_gap   = 0;
        end else begin
            if (push && full) begin
                n_in_stalls++;
            end
            if (push && !full) begin
                decode_byte(i_data);
                n_bytes++;
                if (i_data.is_final) begin
                    n_strings++;
                end
                tx_gap = pick_gap(tx_idle_pct);
            end
            if (!push || !full) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    push <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    i_data <= pending_bytes.pop_front();
                    push   <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            pop    <= 1'b0;
            rx_gap = 0;
        end else begin
            if (pop && !empty) begin
                n_words++;
                if (decoded_words.size() == 0) begin
                    if (n_errors < 10) begin
                        $display("unexpected word: byte %02h final %0b",
                                 o_data.out_byte, o_data.out_final);
                    end
                    n_errors++;
                end else begin
                    exp_w = decoded_words.pop_front();
                    if (o_data.out_byte !== exp_w.out_byte
                            || o_data.out_final !== exp_w.out_final) begin
                        if (n_errors < 10) begin
                            $display("word %0d: expected %02h final %0b, got %02h final %0b",
                                     n_words, exp_w.out_byte, exp_w.out_final,
                                     o_data.out_byte, o_data.out_final);
                        end
                        n_errors++;
                    end
                end
                rx_gap = pick_gap(rx_idle_pct);
            end
            if (rx_hold) begin
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, decoded_words.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int i;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // escaped zero byte stands for itself
        add_byte(CH_BSLASH, 1'b0);
        add_byte(8'h00, 1'b0);
        for (i = 0; i < 7; i++) begin
            add_byte(CH_BSLASH, 1'b0);
            add_byte(esc_letter(i), 1'b0);
        end
        // two digits, mixed case: 0xAF
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_X, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h66, 1'b0);
        // no digit after x: literal x, then 'g' as text
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_X, 1'b0);
        add_byte(8'h67, 1'b0);
        // one digit then a non-digit: two words in one step
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_X, 1'b0);
        add_byte(8'h35, 1'b0);
        add_byte(8'hFF, 1'b0);
        // string ends right after x
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_X, 1'b1);
        // string ends after x and one digit
        add_byte(CH_BSLASH, 1'b0);
        add_byte(CH_X, 1'b0);
        add_byte(8'h63, 1'b1);
        // lone backslash on the final byte
        add_byte(CH_BSLASH, 1'b1);
        wait_drained();

        tx_idle_pct = 25;
        rx_idle_pct = 25;
        fill_random(600);
        // hold the sender until every word has come back
        wait_drained();

        // stall the result side while bytes keep coming back to back
        tx_idle_pct = 0;
        rx_hold     = 1'b1;
        fill_random(60);
        repeat (100) @(negedge i_clk);
        rx_hold     = 1'b0;

        rx_idle_pct = 0;
        fill_random(400);

        tx_idle_pct = 50;
        rx_idle_pct = 50;
        fill_random(600);

        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("covered %0d bytes in %0d strings, %0d words checked, %0d two-word steps",
                 n_bytes, n_strings, n_words, n_pair_steps);
        $display("input stalled on full for %0d cycles, %0d mismatches",
                 n_in_stalls, n_errors);
        if (n_errors == 0 && decoded_words.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
src/bed_pkg.sv
src/bed_front.sv
src/bed_fifo.sv
src/bed_back.sv
src/backslash_escape_decoder.sv
tb/tb.sv
